FILE: hdl/rmth_pkg.sv
// ----------------------------------------------------------------------------
// rmth_pkg: shared types and constants for the running median block
// Port widths, the sequencer state type and the control word of a cell row.
// ----------------------------------------------------------------------------
package rmth_pkg;

    localparam int CAPACITY_DEF    = 1024;
    localparam int SAMPLE_BITS_DEF = 32;
    localparam int SAMPLE_W        = 32;
    localparam int HELD_W          = 11;

    typedef enum logic [1:0] {
        S_IDLE,
        S_INSERT,
        S_BALANCE,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic ins;
        logic pop;
    } t_chain_ctrl;

endpackage

FILE: hdl/running_median_two_heaps.sv
// ----------------------------------------------------------------------------
// running_median_two_heaps: running median over a stream of samples
// Lower half kept in a descending cell row, upper half in an ascending one;
// the median is read from the head of one of them.
// ----------------------------------------------------------------------------
//  channel | valid       | stall       | payload
//  --------+-------------+-------------+--------------------------------
//  input   | i_in_valid  | o_in_stall  | i_sample, i_restart
//  output  | o_out_valid | i_out_stall | o_median, o_held, o_dropped
//
//  An item passes through accept, insert into one row, rebalance by moving one
//  head across, and load result; a dropped item skips the rebalance. The result
//  is offered from the output register once loaded. Each row step is one shift.
//  Reset is synchronous and clears the counts, sequencer and output valid;
//  cell contents are left as they are and only read below the counts.
//  The next item is taken while a result waits; a stalled output holds it.
// ----------------------------------------------------------------------------
module running_median_two_heaps #(
    parameter int CAPACITY    = rmth_pkg::CAPACITY_DEF,
    parameter int SAMPLE_BITS = rmth_pkg::SAMPLE_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [rmth_pkg::SAMPLE_W-1:0] i_sample,
    input  logic                          i_restart,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [rmth_pkg::SAMPLE_W-1:0] o_median,
    output logic [rmth_pkg::HELD_W-1:0]   o_held,
    output logic                          o_dropped
);

    localparam int HALF     = CAPACITY / 2;
    localparam int DEPTH    = HALF + 1;
    localparam int CNT_W    = $clog2(DEPTH + 1);
    localparam int TOT_W    = CNT_W + 1;
    localparam int WIDE     = (SAMPLE_BITS > rmth_pkg::SAMPLE_W) ?
                              SAMPLE_BITS : rmth_pkg::SAMPLE_W;
    localparam int TOT_WIDE = (TOT_W > rmth_pkg::HELD_W) ? TOT_W : rmth_pkg::HELD_W;

    rmth_pkg::t_state r_state, n_state;

    logic [SAMPLE_BITS-1:0]        r_sample;
    logic [CNT_W-1:0]              r_ucnt, n_ucnt;
    logic [CNT_W-1:0]              r_lcnt, n_lcnt;
    logic                          r_dropped, n_dropped;
    logic                          r_out_valid, n_out_valid;
    logic [rmth_pkg::SAMPLE_W-1:0] r_median, n_median;
    logic [rmth_pkg::HELD_W-1:0]   r_held, n_held;
    logic                          r_out_dropped;

    logic                  accept;
    logic                  out_free;
    logic                  load_out;
    logic [TOT_W-1:0]      total;
    logic                  full;
    logic                  to_upper;
    logic                  up_heavy;
    logic                  low_heavy;
    logic [SAMPLE_BITS-1:0] upper_head;
    logic [SAMPLE_BITS-1:0] lower_head;
    logic [SAMPLE_BITS-1:0] upper_key;
    logic [SAMPLE_BITS-1:0] lower_key;
    logic [SAMPLE_BITS-1:0] med_value;
    logic [WIDE-1:0]       sample_wide;
    logic [WIDE-1:0]       median_wide;
    logic [TOT_WIDE-1:0]   held_wide;
    rmth_pkg::t_chain_ctrl upper_ctrl;
    rmth_pkg::t_chain_ctrl lower_ctrl;

    assign accept    = i_in_valid && (r_state == rmth_pkg::S_IDLE);
    assign out_free  = !r_out_valid || !i_out_stall;
    assign total     = TOT_W'(r_ucnt) + TOT_W'(r_lcnt);
    assign full      = (total >= TOT_W'(CAPACITY));
    assign to_upper  = ((r_ucnt == '0) && (r_lcnt == '0))
                    || ((r_lcnt != '0) && (r_sample > lower_head))
                    || ((r_ucnt != '0) && (r_sample > upper_head));
    assign up_heavy  = TOT_W'(r_ucnt) > (TOT_W'(r_lcnt) + TOT_W'(1));
    assign low_heavy = TOT_W'(r_lcnt) > (TOT_W'(r_ucnt) + TOT_W'(1));

    assign sample_wide = WIDE'(i_sample);
    assign med_value   = (r_ucnt > r_lcnt) ? upper_head :
                         ((r_lcnt != '0) ? lower_head : '0);
    assign median_wide = WIDE'(med_value);
    assign held_wide   = TOT_WIDE'(total);
    assign n_median    = median_wide[rmth_pkg::SAMPLE_W-1:0];
    assign n_held      = held_wide[rmth_pkg::HELD_W-1:0];

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            rmth_pkg::S_IDLE: begin
                if (accept) begin
                    n_state = rmth_pkg::S_INSERT;
                end
            end
            rmth_pkg::S_INSERT: begin
                n_state = full ? rmth_pkg::S_EMIT : rmth_pkg::S_BALANCE;
            end
            rmth_pkg::S_BALANCE: begin
                n_state = rmth_pkg::S_EMIT;
            end
            rmth_pkg::S_EMIT: begin
                if (out_free) begin
                    n_state = rmth_pkg::S_IDLE;
                end
            end
        endcase
    end

    // sequencer outputs
    always_comb begin
        o_in_stall = 1'b1;
        n_ucnt     = r_ucnt;
        n_lcnt     = r_lcnt;
        n_dropped  = r_dropped;
        upper_ctrl = '0;
        lower_ctrl = '0;
        upper_key  = r_sample;
        lower_key  = r_sample;
        load_out   = 1'b0;
        unique case (r_state)
            rmth_pkg::S_IDLE: begin
                o_in_stall = 1'b0;
                if (accept) begin
                    n_dropped = 1'b0;
                    if (i_restart) begin
                        n_ucnt = '0;
                        n_lcnt = '0;
                    end
                end
            end
            rmth_pkg::S_INSERT: begin
                if (full) begin
                    n_dropped = 1'b1;
                end else if (to_upper) begin
                    upper_ctrl.ins = 1'b1;
                    n_ucnt         = r_ucnt + CNT_W'(1);
                end else begin
                    lower_ctrl.ins = 1'b1;
                    n_lcnt         = r_lcnt + CNT_W'(1);
                end
            end
            rmth_pkg::S_BALANCE: begin
                // move the head of the heavier row into the other row
                if (up_heavy) begin
                    upper_ctrl.pop = 1'b1;
                    lower_ctrl.ins = 1'b1;
                    lower_key      = upper_head;
                    n_ucnt         = r_ucnt - CNT_W'(1);
                    n_lcnt         = r_lcnt + CNT_W'(1);
                end else if (low_heavy) begin
                    lower_ctrl.pop = 1'b1;
                    upper_ctrl.ins = 1'b1;
                    upper_key      = lower_head;
                    n_lcnt         = r_lcnt - CNT_W'(1);
                    n_ucnt         = r_ucnt + CNT_W'(1);
                end
            end
            rmth_pkg::S_EMIT: begin
                load_out = out_free;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (load_out) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rmth_pkg::S_IDLE;
            r_ucnt      <= '0;
            r_lcnt      <= '0;
            r_dropped   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_ucnt      <= n_ucnt;
            r_lcnt      <= n_lcnt;
            r_dropped   <= n_dropped;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_sample <= sample_wide[SAMPLE_BITS-1:0];
        end
        if (load_out) begin
            r_median      <= n_median;
            r_held        <= n_held;
            r_out_dropped <= r_dropped;
        end
    end

    rmth_chain #(
        .DEPTH  (DEPTH),
        .WIDTH  (SAMPLE_BITS),
        .IS_MAX (1'b0)
    ) u_upper (
        .i_clk   (i_clk),
        .i_ctrl  (upper_ctrl),
        .i_key   (upper_key),
        .i_count (r_ucnt),
        .o_head  (upper_head)
    );

    rmth_chain #(
        .DEPTH  (DEPTH),
        .WIDTH  (SAMPLE_BITS),
        .IS_MAX (1'b1)
    ) u_lower (
        .i_clk   (i_clk),
        .i_ctrl  (lower_ctrl),
        .i_key   (lower_key),
        .i_count (r_lcnt),
        .o_head  (lower_head)
    );

    assign o_out_valid = r_out_valid;
    assign o_median    = r_median;
    assign o_held      = r_held;
    assign o_dropped   = r_out_dropped;

endmodule

FILE: hdl/rmth_cell.sv
// ----------------------------------------------------------------------------
// rmth_cell: one slot of a sorted cell row
// Holds one value. On insert it keeps its value, takes the key or takes its
// left neighbor's value; on pop it takes its right neighbor's value.
// ----------------------------------------------------------------------------
module rmth_cell #(
    parameter int WIDTH  = rmth_pkg::SAMPLE_BITS_DEF,
    parameter bit IS_MAX = 1'b0
) (
    input  logic                  i_clk,
    input  rmth_pkg::t_chain_ctrl i_ctrl,
    input  logic [WIDTH-1:0]      i_key,
    input  logic                  i_occupied,
    input  logic [WIDTH-1:0]      i_prev_value,
    input  logic                  i_prev_after,
    input  logic [WIDTH-1:0]      i_next_value,
    output logic [WIDTH-1:0]      o_value,
    output logic                  o_after
);

    logic [WIDTH-1:0] r_value;
    logic [WIDTH-1:0] n_value;
    logic             key_first;

    // key_first: the key must sit ahead of this cell's value
    assign key_first = IS_MAX ? (i_key > r_value) : (i_key < r_value);
    assign o_after   = i_occupied && !key_first;
    assign o_value   = r_value;

    always_comb begin
        n_value = r_value;
        priority if (i_ctrl.pop) begin
            n_value = i_next_value;
        end else if (i_ctrl.ins && !o_after) begin
            // the first cell not passed by the key takes it, the rest shift
            n_value = i_prev_after ? i_key : i_prev_value;
        end else begin
            n_value = r_value;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

endmodule

FILE: hdl/rmth_chain.sv
// ----------------------------------------------------------------------------
// rmth_chain: sorted row of cells
// Keeps one half of the samples in order with the best value at cell 0.
// Insert and pop are each a single registered shift; every cell compares against the key.
// ----------------------------------------------------------------------------
module rmth_chain #(
    parameter int DEPTH  = rmth_pkg::CAPACITY_DEF / 2 + 1,
    parameter int WIDTH  = rmth_pkg::SAMPLE_BITS_DEF,
    parameter bit IS_MAX = 1'b0
) (
    input  logic                       i_clk,
    input  rmth_pkg::t_chain_ctrl      i_ctrl,
    input  logic [WIDTH-1:0]           i_key,
    input  logic [$clog2(DEPTH+1)-1:0] i_count,
    output logic [WIDTH-1:0]           o_head
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] value [DEPTH];
    logic             after [DEPTH];

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [WIDTH-1:0] prev_value;
        logic [WIDTH-1:0] next_value;
        logic             prev_after;
        logic             occupied;

        if (g == 0) begin : g_first
            assign prev_value = i_key;
            assign prev_after = 1'b1;
        end else begin : g_mid
            assign prev_value = value[g-1];
            assign prev_after = after[g-1];
        end

        if (g == DEPTH - 1) begin : g_last
            assign next_value = value[g];
        end else begin : g_inner
            assign next_value = value[g+1];
        end

        assign occupied = (CNT_W'(g) < i_count);

        rmth_cell #(
            .WIDTH  (WIDTH),
            .IS_MAX (IS_MAX)
        ) u_cell (
            .i_clk        (i_clk),
            .i_ctrl       (i_ctrl),
            .i_key        (i_key),
            .i_occupied   (occupied),
            .i_prev_value (prev_value),
            .i_prev_after (prev_after),
            .i_next_value (next_value),
            .o_value      (value[g]),
            .o_after      (after[g])
        );
    end

    assign o_head = value[0];

endmodule

FILE: hdl/rmth_checker.sv
// ----------------------------------------------------------------------------
// rmth_checker: port-level checks for the running median block
// Watches the handshakes and result fields of the top level over time.
// ----------------------------------------------------------------------------
module rmth_checker #(
    parameter int CAPACITY = rmth_pkg::CAPACITY_DEF
) (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          o_in_stall,
    input logic                          o_out_valid,
    input logic                          i_out_stall,
    input logic [rmth_pkg::SAMPLE_W-1:0] o_median,
    input logic [rmth_pkg::HELD_W-1:0]   o_held,
    input logic                          o_dropped
);

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result withdrawn while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            $stable(o_median) && $stable(o_held) && $stable(o_dropped))
        else $error("result changed while stalled");

    // one item at a time: busy right after a transfer in
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input taken again before the item finished");

    // a dropped sample only comes from a full store
    a_drop_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_dropped |-> o_held == rmth_pkg::HELD_W'(CAPACITY))
        else $error("sample dropped while store not full");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result offered after reset");

endmodule

bind running_median_two_heaps rmth_checker #(
    .CAPACITY (CAPACITY)
) u_rmth_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_median    (o_median),
    .o_held      (o_held),
    .o_dropped   (o_dropped)
);

FILE: verif/tb_running_median_two_heaps.sv
// ----------------------------------------------------------------------------
// tb_running_median_two_heaps: self-checking bench for the running median
// Streams samples through the block and keeps its own two-heap median
// predictor. Each result is checked field by field against the oldest
// expected one. Covers restarts, equal values, extreme samples, a full store
// with dropped samples, random idling on both channels, and a long output
// hold-off that backs up the input.
// ----------------------------------------------------------------------------
module tb_running_median_two_heaps;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SW             = rmth_pkg::SAMPLE_W;
    localparam int HW             = rmth_pkg::HELD_W;
    localparam int STORE_CAP      = rmth_pkg::CAPACITY_DEF;
    localparam int HALF_SLOTS     = STORE_CAP / 2 + 2;
    localparam int LOWER_HALF     = 0;
    localparam int UPPER_HALF     = 1;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int HOLDOFF_CYCLES = 300;
    localparam int SETTLE_CYCLES  = 8;
    localparam int RESET_CYCLES   = 12;

    typedef struct packed {
        logic [SW-1:0] median;
        logic [HW-1:0] held;
        logic          dropped;
    } median_result_t;

    logic          i_clk       = 1'b0;
    logic          i_rst_n     = 1'b0;
    logic          i_in_valid  = 1'b0;
    logic [SW-1:0] i_sample    = '0;
    logic          i_restart   = 1'b0;
    logic          i_out_stall = 1'b0;
    logic          o_in_stall;
    logic          o_out_valid;
    logic [SW-1:0] o_median;
    logic [HW-1:0] o_held;
    logic          o_dropped;

    // Predictor state: a max-heap for the lower half, a min-heap for the upper half
    logic [SW-1:0]  half_mem [2][HALF_SLOTS];
    int             half_cnt [2];
    median_result_t pending_results[$];

    int send_idle_pct   = 0;
    int recv_stall_pct  = 0;
    int items_sent      = 0;
    int results_checked = 0;
    int drops_seen      = 0;
    int max_held        = 0;
    int fail_count      = 0;
    int idle_cycles     = 0;
    int holdoff_left    = 0;
    bit holdoff_trigger = 1'b0;
    bit holdoff_seen    = 1'b0;
    bit input_backed_up = 1'b0;

    always #10 i_clk = ~i_clk;

    running_median_two_heaps i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_sample    (i_sample),
        .i_restart   (i_restart),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_median    (o_median),
        .o_held      (o_held),
        .o_dropped   (o_dropped)
    );

    function automatic bit ranks_above(int h, logic [SW-1:0] a, logic [SW-1:0] b);
        return (h == LOWER_HALF) ? (a > b) : (a < b);
    endfunction

    function automatic void half_push(int h, logic [SW-1:0] v);
        int            i;
        int            p;
        bit            done;
        logic [SW-1:0] t;
        i = half_cnt[h];
        if (i >= HALF_SLOTS) return;
        half_mem[h][i] = v;
        half_cnt[h] = i + 1;
        done = 1'b0;
        while (i > 0 && !done) begin
            p = (i - 1) / 2;
            if (ranks_above(h, half_mem[h][i], half_mem[h][p])) begin
                t = half_mem[h][i];
                half_mem[h][i] = half_mem[h][p];
                half_mem[h][p] = t;
                i = p;
            end else begin
                done = 1'b1;
            end
        end
    endfunction

    function automatic logic [SW-1:0] half_pop(int h);
        int            n;
        int            i;
        int            l;
        int            r;
        int            best;
        bit            done;
        logic [SW-1:0] top;
        logic [SW-1:0] t;
        n = half_cnt[h];
        if (n == 0) return '0;
        top = half_mem[h][0];
        n--;
        half_mem[h][0] = half_mem[h][n];
        half_cnt[h] = n;
        i = 0;
        done = 1'b0;
        while (!done) begin
            l = 2 * i + 1;
            r = l + 1;
            best = i;
            if (l < n && ranks_above(h, half_mem[h][l], half_mem[h][best])) best = l;
            if (r < n && ranks_above(h, half_mem[h][r], half_mem[h][best])) best = r;
            if (best == i) begin
                done = 1'b1;
            end else begin
                t = half_mem[h][i];
                half_mem[h][i] = half_mem[h][best];
                half_mem[h][best] = t;
                i = best;
            end
        end
        return top;
    endfunction

    // Advance the predictor by one sample and return the result it should give
    function automatic median_result_t median_after(logic [SW-1:0] s, logic rs);
        median_result_t r;
        bit             to_upper;
        r = '0;
        if (rs) begin
            half_cnt[LOWER_HALF] = 0;
            half_cnt[UPPER_HALF] = 0;
        end
        if (half_cnt[LOWER_HALF] + half_cnt[UPPER_HALF] >= STORE_CAP) begin
            r.dropped = 1'b1;
        end else begin
            to_upper = (half_cnt[LOWER_HALF] == 0 && half_cnt[UPPER_HALF] == 0)
                || (half_cnt[LOWER_HALF] > 0 && s > half_mem[LOWER_HALF][0])
                || (half_cnt[UPPER_HALF] > 0 && s > half_mem[UPPER_HALF][0]);
            half_push(to_upper ? UPPER_HALF : LOWER_HALF, s);
            if (half_cnt[UPPER_HALF] > half_cnt[LOWER_HALF] + 1)
                half_push(LOWER_HALF, half_pop(UPPER_HALF));
            else if (half_cnt[LOWER_HALF] > half_cnt[UPPER_HALF] + 1)
                half_push(UPPER_HALF, half_pop(LOWER_HALF));
        end
        if (half_cnt[UPPER_HALF] > half_cnt[LOWER_HALF])
            r.median = half_mem[UPPER_HALF][0];
        else if (half_cnt[LOWER_HALF] > 0)
            r.median = half_mem[LOWER_HALF][0];
        r.held = HW'(half_cnt[LOWER_HALF] + half_cnt[UPPER_HALF]);
        return r;
    endfunction

    // Mix wide values, a narrow range for many repeats, the extremes, and a band around the sign boundary
    function automatic logic [SW-1:0] pick_sample();
        case ($urandom_range(3))
            0: return $urandom();
            1: return SW'($urandom_range(15));
            2: begin
                case ($urandom_range(3))
                    0: return '0;
                    1: return '1;
                    2: return {1'b1, {(SW-1){1'b0}}};
                    default: return {1'b0, {(SW-1){1'b1}}};
                endcase
            end
            default: return SW'($urandom_range(1000)) + 32'h7fff_fe00;
        endcase
    endfunction

    task automatic send_sample(input logic [SW-1:0] s, input logic rs);
        median_result_t r;
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_sample   <= s;
        i_restart  <= rs;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        r = median_after(s, rs);
        pending_results.push_back(r);
        items_sent++;
        if (r.dropped) drops_seen++;
        if (int'(r.held) > max_held) max_held = int'(r.held);
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic test_directed();
        send_sample(32'h0000_0000, 1'b1);
        send_sample(32'hffff_ffff, 1'b0);
        send_sample(32'h0000_0000, 1'b0);
        send_sample(32'h0000_0007, 1'b0);
        send_sample(32'h0000_0007, 1'b0);
        send_sample(32'h0000_0007, 1'b0);
        send_sample(32'h8000_0000, 1'b0);
        send_sample(32'h0000_0001, 1'b0);
        send_sample(32'hffff_fffe, 1'b0);
        // restart with a sample, then back-to-back restarts
        send_sample(32'hffff_ffff, 1'b1);
        send_sample(32'hffff_ffff, 1'b0);
        send_sample(32'h0000_0000, 1'b0);
        send_sample(32'h0000_0000, 1'b0);
        send_sample(32'h1234_5678, 1'b1);
        send_sample(32'h0000_0001, 1'b1);
        send_sample(32'h5555_5555, 1'b0);
        send_sample(32'haaaa_aaaa, 1'b0);
        wait_drained();
    endtask

    task automatic test_store_full();
        send_sample(pick_sample(), 1'b1);
        repeat (STORE_CAP - 1) send_sample(pick_sample(), 1'b0);
        // store is full now: these are discarded
        repeat (6) send_sample(pick_sample(), 1'b0);
        send_sample(pick_sample(), 1'b1);
        repeat (6) send_sample(pick_sample(), 1'b0);
        wait_drained();
    endtask

    task automatic test_output_holdoff();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        holdoff_trigger <= ~holdoff_trigger;
        repeat (24) send_sample(pick_sample(), $urandom_range(15) == 0);
        wait_drained();
    endtask

    task automatic test_random_traffic(input int idle_pct, input int stall_pct, input int n);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (n) send_sample(pick_sample(), $urandom_range(47) == 0);
        wait_drained();
    endtask

    // Output side: random stall plus the long hold-off when triggered
    always @(posedge i_clk) begin
        if (holdoff_trigger != holdoff_seen) begin
            holdoff_seen <= holdoff_trigger;
            holdoff_left <= HOLDOFF_CYCLES;
        end else if (holdoff_left > 0) begin
            holdoff_left <= holdoff_left - 1;
        end
        i_out_stall <= (holdoff_left > 0) || ($urandom_range(99) < recv_stall_pct);
        if (holdoff_left > 0 && o_in_stall) input_backed_up <= 1'b1;
    end

    always @(posedge i_clk) begin
        median_result_t want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                $error("result with nothing expected: median %0h held %0d dropped %0b",
                    o_median, o_held, o_dropped);
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                results_checked++;
                if (o_median !== want.median) begin
                    $error("median: expected %0h, got %0h", want.median, o_median);
                    fail_count++;
                end
                if (o_held !== want.held) begin
                    $error("held: expected %0d, got %0d", want.held, o_held);
                    fail_count++;
                end
                if (o_dropped !== want.dropped) begin
                    $error("dropped: expected %0b, got %0b", want.dropped, o_dropped);
                    fail_count++;
                end
            end
        end
    end

    // Count cycles without any transfer; a hang ends the run
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
                $display("== FAIL ==");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    initial begin
        half_cnt[LOWER_HALF] = 0;
        half_cnt[UPPER_HALF] = 0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_store_full();
        test_output_holdoff();
        test_random_traffic(0, 0, 220);
        test_random_traffic(69, 0, 220);
        test_random_traffic(0, 69, 220);
        test_random_traffic(19, 19, 220);

        if (pending_results.size() != 0) begin
            $error("%0d expected results never arrived", pending_results.size());
            fail_count++;
        end
        $display("Checked %0d results from %0d samples: restarts, repeats, extremes, four idling mixes.",
            results_checked, items_sent);
        $display("Store reached %0d held, %0d samples discarded; input backed up under hold-off: %0b",
            max_held, drops_seen, input_backed_up);
        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
